>>> hdl/uvopa_pkg.sv
// ----------------------------------------------------------------------------
// uvopa_pkg
// Types, codes and helpers for the undervoltage and overpower alarm block.
// ----------------------------------------------------------------------------
package uvopa_pkg;

  localparam int unsigned POWER_W = 18;
  localparam int unsigned VOLTS_W = 12;
  localparam int unsigned SECS_W  = 17;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned EVENT_W = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  // 90.1 V in 0.1 V units
  localparam logic [VOLTS_W-1:0] UV_MIN_VOLTS = 12'd901;
  localparam logic [SECS_W-1:0]  DAY_SECONDS  = 17'd86400;

  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE   = 2'd0,
    MODE_UV_CLEAR = 2'd1,
    MODE_OP_CLEAR = 2'd2,
    MODE_IDLE     = 2'd3
  } mode_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE  = 2'd0,
    EV_BEGIN = 2'd1,
    EV_END   = 2'd2
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UV_ENABLE    = 2'd0,
    CFG_UV_THRESHOLD = 2'd1,
    CFG_OP_ENABLE    = 2'd2,
    CFG_OP_THRESHOLD = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              in_alarm;
    logic              flag;
    event_t            event_code;
    logic [SECS_W-1:0] start_time;
  } alarm_t;

  typedef struct packed {
    alarm_t            st;
    logic [SECS_W-1:0] duration;
  } alarm_res_t;

  // one sample step of a two-state alarm
  function automatic alarm_res_t alarm_next(
    input alarm_t            st,
    input logic              en,
    input logic              trig,
    input logic              hold,
    input logic [SECS_W-1:0] now
  );
    alarm_res_t         res;
    logic [SECS_W:0]    diff;
    res.st       = st;
    res.duration = '0;
    diff         = {1'b0, now} - {1'b0, st.start_time};
    if (en) begin
      if (!st.in_alarm) begin
        res.st.flag       = 1'b0;
        res.st.event_code = EV_NONE;
        if (trig) begin
          res.st.in_alarm   = 1'b1;
          res.st.flag       = 1'b1;
          res.st.event_code = EV_BEGIN;
          res.st.start_time = now;
        end
      end else begin
        res.st.event_code = EV_NONE;
        if (!hold) begin
          res.st.in_alarm   = 1'b0;
          res.st.event_code = EV_END;
          // negative difference means the alarm ran across midnight
          if (diff[SECS_W]) begin
            res.duration = SECS_W'(diff + {1'b0, DAY_SECONDS});
          end else begin
            res.duration = diff[SECS_W-1:0];
          end
        end
      end
    end
    return res;
  endfunction

endpackage

>>> hdl/undervoltage_overpower_alarm.sv
// Each accepted input word passes the input register, then the result register.
// Throughput: one word per cycle; the
// input register advances whenever the result register is empty or taken.
// Reset (rst_n low, synchronous) clears the configuration registers, both
// alarm states and all valid flags; there is no clearing pass.
// ----------------------------------------------------------------------------
// undervoltage_overpower_alarm
// Undervoltage and overpower threshold alarms with begin/end events and
// alarm duration modulo one day.
// ----------------------------------------------------------------------------
module undervoltage_overpower_alarm (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               cfg_wr_en,
  input  logic [uvopa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uvopa_pkg::CFG_DATA_W-1:0]   cfg_wdata,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [uvopa_pkg::MODE_W-1:0]       in_mode,
  input  logic [uvopa_pkg::POWER_W-1:0]      in_total_power,
  input  logic [uvopa_pkg::VOLTS_W-1:0]      in_phase1_volts,
  input  logic [uvopa_pkg::VOLTS_W-1:0]      in_phase2_volts,
  input  logic [uvopa_pkg::SECS_W-1:0]       in_seconds_of_day,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_uv_active,
  output logic [uvopa_pkg::EVENT_W-1:0]      out_uv_event,
  output logic [uvopa_pkg::SECS_W-1:0]       out_uv_duration,
  output logic                               out_op_active,
  output logic [uvopa_pkg::EVENT_W-1:0]      out_op_event,
  output logic [uvopa_pkg::SECS_W-1:0]       out_op_duration
);

  // configuration
  logic                              uv_enable_r;
  logic [uvopa_pkg::VOLTS_W-1:0]     uv_threshold_r;
  logic                              op_enable_r;
  logic [uvopa_pkg::POWER_W-1:0]     op_threshold_r;

  // input register
  logic                              s1_valid_r;
  logic [uvopa_pkg::MODE_W-1:0]      s1_mode_r;
  logic [uvopa_pkg::POWER_W-1:0]     s1_power_r;
  logic [uvopa_pkg::VOLTS_W-1:0]     s1_v1_r;
  logic [uvopa_pkg::VOLTS_W-1:0]     s1_v2_r;
  logic [uvopa_pkg::SECS_W-1:0]      s1_secs_r;

  // alarm state
  uvopa_pkg::alarm_t                 uv_r, uv_nxt;
  uvopa_pkg::alarm_t                 op_r, op_nxt;
  logic [uvopa_pkg::SECS_W-1:0]      uv_dur_nxt, op_dur_nxt;

  // result register
  logic                              out_valid_r;
  logic                              out_uv_active_r;
  logic [uvopa_pkg::EVENT_W-1:0]     out_uv_event_r;
  logic [uvopa_pkg::SECS_W-1:0]      out_uv_duration_r;
  logic                              out_op_active_r;
  logic [uvopa_pkg::EVENT_W-1:0]     out_op_event_r;
  logic [uvopa_pkg::SECS_W-1:0]      out_op_duration_r;

  logic                              advance;
  logic                              fire;
  logic [uvopa_pkg::SECS_W-1:0]      now_wrapped;
  logic                              uv_low;
  logic                              uv_trig;
  logic                              op_high;
  uvopa_pkg::alarm_res_t             uv_res;
  uvopa_pkg::alarm_res_t             op_res;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uv_enable_r    <= 1'b0;
      uv_threshold_r <= '0;
      op_enable_r    <= 1'b0;
      op_threshold_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (uvopa_pkg::cfg_idx_t'(cfg_index))
        uvopa_pkg::CFG_UV_ENABLE:    uv_enable_r    <= cfg_wdata[0];
        uvopa_pkg::CFG_UV_THRESHOLD: uv_threshold_r <= cfg_wdata[uvopa_pkg::VOLTS_W-1:0];
        uvopa_pkg::CFG_OP_ENABLE:    op_enable_r    <= cfg_wdata[0];
        uvopa_pkg::CFG_OP_THRESHOLD: op_threshold_r <= cfg_wdata[uvopa_pkg::POWER_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode_r  <= in_mode;
      s1_power_r <= in_total_power;
      s1_v1_r    <= in_phase1_volts;
      s1_v2_r    <= in_phase2_volts;
      s1_secs_r  <= in_seconds_of_day;
    end
  end

  // sample evaluation
  always_comb begin
    // time is below two days, one subtract brings it into range
    if (s1_secs_r >= uvopa_pkg::DAY_SECONDS) begin
      now_wrapped = s1_secs_r - uvopa_pkg::DAY_SECONDS;
    end else begin
      now_wrapped = s1_secs_r;
    end
    uv_low  = (s1_v1_r < uv_threshold_r) || (s1_v2_r < uv_threshold_r);
    uv_trig = (s1_v1_r > uvopa_pkg::UV_MIN_VOLTS) && (s1_v2_r > uvopa_pkg::UV_MIN_VOLTS)
              && uv_low;
    op_high = s1_power_r > op_threshold_r;
    uv_res  = uvopa_pkg::alarm_next(uv_r, uv_enable_r, uv_trig, uv_low, now_wrapped);
    op_res  = uvopa_pkg::alarm_next(op_r, op_enable_r, op_high, op_high, now_wrapped);

    uv_nxt     = uv_r;
    op_nxt     = op_r;
    uv_dur_nxt = '0;
    op_dur_nxt = '0;
    case (uvopa_pkg::mode_t'(s1_mode_r))
      uvopa_pkg::MODE_SAMPLE: begin
        uv_nxt     = uv_res.st;
        op_nxt     = op_res.st;
        uv_dur_nxt = uv_res.duration;
        op_dur_nxt = op_res.duration;
      end
      // start time is kept on a clear
      uvopa_pkg::MODE_UV_CLEAR: begin
        uv_nxt.in_alarm   = 1'b0;
        uv_nxt.flag       = 1'b0;
        uv_nxt.event_code = uvopa_pkg::EV_NONE;
      end
      uvopa_pkg::MODE_OP_CLEAR: begin
        op_nxt.in_alarm   = 1'b0;
        op_nxt.flag       = 1'b0;
        op_nxt.event_code = uvopa_pkg::EV_NONE;
      end
      default: ;
    endcase
  end

  // alarm state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uv_r <= '0;
      op_r <= '0;
    end else if (fire) begin
      uv_r <= uv_nxt;
      op_r <= op_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_uv_active_r   <= uv_nxt.flag;
      out_uv_event_r    <= uv_nxt.event_code;
      out_uv_duration_r <= uv_dur_nxt;
      out_op_active_r   <= op_nxt.flag;
      out_op_event_r    <= op_nxt.event_code;
      out_op_duration_r <= op_dur_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_uv_active   = out_uv_active_r;
  assign out_uv_event    = out_uv_event_r;
  assign out_uv_duration = out_uv_duration_r;
  assign out_op_active   = out_op_active_r;
  assign out_op_event    = out_op_event_r;
  assign out_op_duration = out_op_duration_r;

`ifndef SYNTHESIS
  a_uv_dur_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_uv_duration != '0) |-> out_uv_event == 2'(uvopa_pkg::EV_END))
    else $error("uv duration without end word");

  a_op_dur_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_op_duration != '0) |-> out_op_event == 2'(uvopa_pkg::EV_END))
    else $error("op duration without end word");

  a_begin_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_uv_event == 2'(uvopa_pkg::EV_BEGIN)
                   || out_op_event == 2'(uvopa_pkg::EV_BEGIN)))
    |-> ((out_uv_event != 2'(uvopa_pkg::EV_BEGIN) || out_uv_active)
         && (out_op_event != 2'(uvopa_pkg::EV_BEGIN) || out_op_active)))
    else $error("begin word without active flag");

  a_in_alarm_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (uv_r.in_alarm || op_r.in_alarm)
    |-> ((!uv_r.in_alarm || uv_r.flag) && (!op_r.in_alarm || op_r.flag)))
    else $error("alarm state without flag");

  a_dur_below_day: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_uv_duration < uvopa_pkg::DAY_SECONDS
                   && out_op_duration < uvopa_pkg::DAY_SECONDS))
    else $error("duration not below one day");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the undervoltage and overpower alarm block. A
// queue-fed driver pushes sample and clear words under random idling, a
// monitor stalls the result side at random and compares every result word
// against an in-bench model of both alarms, across several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import uvopa_pkg::*;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned SECS_MAX     = 131071;
  localparam int unsigned POWER_MAX    = 262143;
  localparam int unsigned VOLTS_MAX    = 4095;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct {
    mode_t              mode;
    logic [POWER_W-1:0] power;
    logic [VOLTS_W-1:0] v1;
    logic [VOLTS_W-1:0] v2;
    logic [SECS_W-1:0]  secs;
  } sample_t;

  typedef struct packed {
    logic              uv_active;
    event_t            uv_event;
    logic [SECS_W-1:0] uv_duration;
    logic              op_active;
    event_t            op_event;
    logic [SECS_W-1:0] op_duration;
  } alarm_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [MODE_W-1:0]     in_mode;
  logic [POWER_W-1:0]    in_total_power;
  logic [VOLTS_W-1:0]    in_phase1_volts;
  logic [VOLTS_W-1:0]    in_phase2_volts;
  logic [SECS_W-1:0]     in_seconds_of_day;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_uv_active;
  logic [EVENT_W-1:0]    out_uv_event;
  logic [SECS_W-1:0]     out_uv_duration;
  logic                  out_op_active;
  logic [EVENT_W-1:0]    out_op_event;
  logic [SECS_W-1:0]     out_op_duration;

  sample_t     pending_q[$];
  alarm_word_t alarm_words_q[$];
  sample_t     drv_sample;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned stuck_cycles;
  int unsigned day_clock;

  // register copies
  logic               uv_en_r;
  logic [VOLTS_W-1:0] uv_thr_r;
  logic               op_en_r;
  logic [POWER_W-1:0] op_thr_r;

  // alarm state copies
  logic              uv_in_alarm_r, uv_flag_r;
  event_t            uv_event_r;
  logic [SECS_W-1:0] uv_start_r;
  logic              op_in_alarm_r, op_flag_r;
  event_t            op_event_r;
  logic [SECS_W-1:0] op_start_r;

  undervoltage_overpower_alarm DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_total_power    (in_total_power),
    .in_phase1_volts   (in_phase1_volts),
    .in_phase2_volts   (in_phase2_volts),
    .in_seconds_of_day (in_seconds_of_day),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_uv_active     (out_uv_active),
    .out_uv_event      (out_uv_event),
    .out_uv_duration   (out_uv_duration),
    .out_op_active     (out_op_active),
    .out_op_event      (out_op_event),
    .out_op_duration   (out_op_duration)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // seconds between start and now, both folded into one day first
  function automatic logic [SECS_W-1:0] day_span(input logic [SECS_W-1:0] now_s,
                                                 input logic [SECS_W-1:0] start_s);
    int unsigned n;
    int unsigned s;
    n = now_s % SECS_PER_DAY;
    s = start_s % SECS_PER_DAY;
    return SECS_W'((n >= s) ? (n - s) : (n + SECS_PER_DAY - s));
  endfunction

  function automatic alarm_word_t predict_alarms(input sample_t s);
    alarm_word_t w;
    logic        low;
    logic        high;
    w.uv_duration = '0;
    w.op_duration = '0;
    case (s.mode)
      MODE_UV_CLEAR: begin
        uv_in_alarm_r = 1'b0;
        uv_flag_r     = 1'b0;
        uv_event_r    = EV_NONE;
      end
      MODE_OP_CLEAR: begin
        op_in_alarm_r = 1'b0;
        op_flag_r     = 1'b0;
        op_event_r    = EV_NONE;
      end
      MODE_SAMPLE: begin
        if (uv_en_r) begin
          low = (s.v1 < uv_thr_r) || (s.v2 < uv_thr_r);
          if (!uv_in_alarm_r) begin
            uv_flag_r  = 1'b0;
            uv_event_r = EV_NONE;
            if (s.v1 > UV_MIN_VOLTS && s.v2 > UV_MIN_VOLTS && low) begin
              uv_in_alarm_r = 1'b1;
              uv_flag_r     = 1'b1;
              uv_event_r    = EV_BEGIN;
              uv_start_r    = s.secs;
            end
          end else begin
            uv_event_r = EV_NONE;
            if (!low) begin
              uv_in_alarm_r = 1'b0;
              uv_event_r    = EV_END;
              w.uv_duration = day_span(s.secs, uv_start_r);
            end
          end
        end
        if (op_en_r) begin
          high = s.power > op_thr_r;
          if (!op_in_alarm_r) begin
            op_flag_r  = 1'b0;
            op_event_r = EV_NONE;
            if (high) begin
              op_in_alarm_r = 1'b1;
              op_flag_r     = 1'b1;
              op_event_r    = EV_BEGIN;
              op_start_r    = s.secs;
            end
          end else begin
            op_event_r = EV_NONE;
            if (!high) begin
              op_in_alarm_r = 1'b0;
              op_event_r    = EV_END;
              w.op_duration = day_span(s.secs, op_start_r);
            end
          end
        end
      end
      default: ;
    endcase
    w.uv_active = uv_flag_r;
    w.uv_event  = uv_event_r;
    w.op_active = op_flag_r;
    w.op_event  = op_event_r;
    return w;
  endfunction

  function automatic int unsigned near_value(input int unsigned center,
                                             input int unsigned maxv);
    int v;
    v = int'(center) + int'($urandom_range(16)) - 8;
    if (v < 0) v = 0;
    if (v > int'(maxv)) v = int'(maxv);
    return v;
  endfunction

  function automatic logic [VOLTS_W-1:0] random_volts();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return VOLTS_W'(near_value(uv_thr_r, VOLTS_MAX));
    if (r < 6) return VOLTS_W'(near_value(UV_MIN_VOLTS, VOLTS_MAX));
    if (r < 9) return VOLTS_W'($urandom_range(3000, 902));
    return VOLTS_W'($urandom_range(VOLTS_MAX));
  endfunction

  function automatic sample_t random_sample();
    sample_t     s;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 82)      s.mode = MODE_SAMPLE;
    else if (r < 88) s.mode = MODE_UV_CLEAR;
    else if (r < 94) s.mode = MODE_OP_CLEAR;
    else             s.mode = MODE_IDLE;
    if ($urandom_range(9) < 7) s.power = POWER_W'(near_value(op_thr_r, POWER_MAX));
    else                       s.power = POWER_W'($urandom_range(POWER_MAX));
    s.v1 = random_volts();
    s.v2 = random_volts();
    // mostly a clock moving forward, with midnight wraps and raw times past a day
    if ($urandom_range(3) == 0) day_clock = (day_clock + $urandom_range(20000, 1)) % SECS_PER_DAY;
    else                        day_clock = (day_clock + $urandom_range(60, 1)) % SECS_PER_DAY;
    r = $urandom_range(19);
    if (r == 0 && day_clock <= SECS_MAX - SECS_PER_DAY) s.secs = SECS_W'(day_clock + SECS_PER_DAY);
    else if (r == 1) s.secs = SECS_W'($urandom_range(SECS_MAX));
    else             s.secs = SECS_W'(day_clock);
    return s;
  endfunction

  task automatic push_sample(input mode_t m, input int unsigned p, input int unsigned v1,
                             input int unsigned v2, input int unsigned t);
    sample_t s;
    s.mode  = m;
    s.power = POWER_W'(p);
    s.v1    = VOLTS_W'(v1);
    s.v2    = VOLTS_W'(v2);
    s.secs  = SECS_W'(t);
    pending_q.push_back(s);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_UV_ENABLE:    uv_en_r  = val[0];
      CFG_UV_THRESHOLD: uv_thr_r = VOLTS_W'(val);
      CFG_OP_ENABLE:    op_en_r  = val[0];
      CFG_OP_THRESHOLD: op_thr_r = POWER_W'(val);
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned uv_en, input int unsigned uv_thr,
                           input int unsigned op_en, input int unsigned op_thr,
                           input int unsigned idle_pct, input int unsigned stall_pct);
    write_reg(CFG_UV_ENABLE, uv_en);
    write_reg(CFG_UV_THRESHOLD, uv_thr);
    write_reg(CFG_OP_ENABLE, op_en);
    write_reg(CFG_OP_THRESHOLD, op_thr);
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || alarm_words_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // driver: a word leaves when it is taken, the next one may follow at once
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) alarm_words_q.push_back(predict_alarms(drv_sample));
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_sample = pending_q.pop_front();
        in_valid          <= 1'b1;
        in_mode           <= drv_sample.mode;
        in_total_power    <= drv_sample.power;
        in_phase1_volts   <= drv_sample.v1;
        in_phase2_volts   <= drv_sample.v2;
        in_seconds_of_day <= drv_sample.secs;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    alarm_word_t got;
    alarm_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_uv_active, event_t'(out_uv_event), out_uv_duration,
                out_op_active, event_t'(out_op_event), out_op_duration};
        if (alarm_words_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result word with none expected: uv %0d/%0d/%0d op %0d/%0d/%0d",
                     $realtime, got.uv_active, got.uv_event, got.uv_duration,
                     got.op_active, got.op_event, got.op_duration);
        end else begin
          want = alarm_words_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: exp uv %0d/%0d/%0d op %0d/%0d/%0d, got uv %0d/%0d/%0d op %0d/%0d/%0d",
                       $realtime, want.uv_active, want.uv_event, want.uv_duration,
                       want.op_active, want.op_event, want.op_duration,
                       got.uv_active, got.uv_event, got.uv_duration,
                       got.op_active, got.op_event, got.op_duration);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_mode           = '0;
    in_total_power    = '0;
    in_phase1_volts   = '0;
    in_phase2_volts   = '0;
    in_seconds_of_day = '0;
    out_stall         = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    mismatch_count    = 0;
    stuck_cycles      = 0;
    day_clock         = 0;
    uv_en_r = 1'b0; uv_thr_r = '0; op_en_r = 1'b0; op_thr_r = '0;
    uv_in_alarm_r = 1'b0; uv_flag_r = 1'b0; uv_event_r = EV_NONE; uv_start_r = '0;
    op_in_alarm_r = 1'b0; op_flag_r = 1'b0; op_event_r = EV_NONE; op_start_r = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed words
    configure(1, 2200, 1, 50000, 0, 0);
    @(negedge clk);
    push_sample(MODE_SAMPLE, 0, 0, 0, 0);
    push_sample(MODE_SAMPLE, 0, 901, 1000, 10);         // 90.1 V is not above the floor
    push_sample(MODE_SAMPLE, 50000, 902, 2300, 20);     // uv begins, power equal to threshold
    push_sample(MODE_SAMPLE, 50001, 2199, 2300, 30);    // uv holds, op begins
    push_sample(MODE_SAMPLE, 50000, 2200, 2200, 95);    // both end
    push_sample(MODE_SAMPLE, 0, 2500, 2500, 100);       // flags clear after end
    push_sample(MODE_SAMPLE, POWER_MAX, VOLTS_MAX, VOLTS_MAX, 86000);
    push_sample(MODE_SAMPLE, POWER_MAX, VOLTS_MAX, VOLTS_MAX, 200);
    push_sample(MODE_SAMPLE, 0, VOLTS_MAX, VOLTS_MAX, 300);  // op ends across midnight
    push_sample(MODE_SAMPLE, POWER_MAX, 1000, VOLTS_MAX, SECS_MAX); // time past one day
    push_sample(MODE_IDLE, POWER_MAX, VOLTS_MAX, VOLTS_MAX, SECS_MAX);
    push_sample(MODE_UV_CLEAR, POWER_MAX, VOLTS_MAX, VOLTS_MAX, SECS_MAX);
    push_sample(MODE_SAMPLE, 60000, 2500, 2500, 44700);
    push_sample(MODE_OP_CLEAR, 0, 0, 0, 0);
    push_sample(MODE_UV_CLEAR, 0, 0, 0, 0);
    push_sample(MODE_OP_CLEAR, 0, 0, 0, 0);
    push_sample(MODE_SAMPLE, 50001, 1000, 1000, 86399);
    push_sample(MODE_SAMPLE, 50001, 1000, 1000, 86399);
    push_sample(MODE_SAMPLE, 0, 2300, 2300, 86400);     // both end, raw time wraps
    push_sample(MODE_IDLE, POWER_MAX, VOLTS_MAX, VOLTS_MAX, SECS_MAX);
    wait_drained();

    // random words over several register settings, the first with both alarms disabled while still holding an end event
    for (int ph = 1; ph <= 7; ph++) begin
      case (ph)
        1: configure(0, 0, 0, POWER_MAX, 0, 0);
        2: configure(1, 2200, 1, 50000, 0, 0);
        3: configure(1, $urandom_range(3000, 950), 1, $urandom_range(POWER_MAX), 86, 0);
        4: configure(1, $urandom_range(3000, 950), 1, $urandom_range(POWER_MAX), 0, 86);
        5: configure(1, VOLTS_MAX, 1, 0, 31, 31);
        6: configure(1, $urandom_range(3000, 950), 0, $urandom_range(POWER_MAX), 0, 0);
        default: configure(0, 3000, 1, $urandom_range(POWER_MAX), 31, 31);
      endcase
      @(negedge clk);
      repeat ((ph == 1) ? 40 : 110) pending_q.push_back(random_sample());
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
